// ===== src/fbsp_pkg.sv =====
// Package for the position string parser: character codes, phase and kind types,
// the result word structure and the piece letter decode function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbsp_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned SQ_W     = 6;
    localparam int unsigned PIECE_W  = 4;
    localparam int unsigned CASTLE_W = 4;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned OUT_W    = 16;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_EIGHT = 8'h38;
    localparam logic [CH_W-1:0] CH_LOW_W = 8'h77;
    localparam logic [CH_W-1:0] CH_UP_K  = 8'h4B;
    localparam logic [CH_W-1:0] CH_UP_Q  = 8'h51;
    localparam logic [CH_W-1:0] CH_LOW_K = 8'h6B;
    localparam logic [CH_W-1:0] CH_LOW_Q = 8'h71;

    localparam logic [POS_W-1:0] RANK_TOP = 4'd8;
    localparam logic [POS_W-1:0] FILE_MAX = 4'd15;
    localparam logic [POS_W-1:0] FILE_END = 4'd8;

    localparam logic [CASTLE_W-1:0] CASTLE_WK = 4'b0001;
    localparam logic [CASTLE_W-1:0] CASTLE_WQ = 4'b0010;
    localparam logic [CASTLE_W-1:0] CASTLE_BK = 4'b0100;
    localparam logic [CASTLE_W-1:0] CASTLE_BQ = 4'b1000;

    typedef enum logic [2:0] {
        PH_PLACE  = 3'd0,
        PH_SIDE   = 3'd1,
        PH_SEP    = 3'd2,
        PH_CASTLE = 3'd3,
        PH_EP     = 3'd4,
        PH_HALF   = 3'd5,
        PH_FULL   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SQUARE = 2'd0,
        KIND_SIDE   = 2'd1,
        KIND_CASTLE = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic                vld;
        t_kind               kind;
        logic [SQ_W-1:0]     square;
        logic [PIECE_W-1:0]  piece;
        logic                side;
        logic [CASTLE_W-1:0] castle_mask;
    } t_result;

    function automatic logic [PIECE_W-1:0] piece_code(input logic [CH_W-1:0] c);
        logic [PIECE_W-1:0] p;
        unique case (c)
            8'h50:   p = 4'd1;
            8'h4E:   p = 4'd2;
            8'h42:   p = 4'd3;
            8'h52:   p = 4'd4;
            8'h51:   p = 4'd5;
            8'h4B:   p = 4'd6;
            8'h70:   p = 4'd7;
            8'h6E:   p = 4'd8;
            8'h62:   p = 4'd9;
            8'h72:   p = 4'd10;
            8'h71:   p = 4'd11;
            8'h6B:   p = 4'd12;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/fbsp_parse.sv =====
// Parser core: phase, rank, file and castling registers with the per-character
// next-state and result logic. Depends on fbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbsp_parse (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  wire  [fbsp_pkg::CH_W-1:0]    i_ch,
    output fbsp_pkg::t_result            o_res
);
    import fbsp_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [POS_W-1:0]    r_rank,   n_rank;
    logic [POS_W-1:0]    r_file,   n_file;
    logic [CASTLE_W-1:0] r_castle, n_castle;

    logic [POS_W:0]      file_sum;
    logic [POS_W-1:0]    rank_m1;
    logic                on_board;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PLACE;
            r_rank   <= RANK_TOP;
            r_file   <= '0;
            r_castle <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_rank   <= n_rank;
            r_file   <= n_file;
            r_castle <= n_castle;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_rank   = r_rank;
        n_file   = r_file;
        n_castle = r_castle;
        o_res    = '0;
        file_sum = {1'b0, r_file} + {1'b0, i_ch[POS_W-1:0]};
        rank_m1  = r_rank - 4'd1;
        on_board = (r_rank != '0) && (r_file < FILE_END);

        if (i_ch == CH_NUL) begin
            n_phase    = PH_PLACE;
            n_rank     = RANK_TOP;
            n_file     = '0;
            n_castle   = '0;
            o_res.vld  = 1'b1;
            o_res.kind = KIND_DONE;
        end else begin
            unique case (r_phase)
                PH_PLACE: begin
                    if (i_ch == CH_SPACE) begin
                        n_phase = PH_SIDE;
                    end else if (i_ch == CH_SLASH) begin
                        if (r_rank != '0) begin
                            n_rank = rank_m1;
                        end
                        n_file = '0;
                    end else if (i_ch >= CH_ZERO && i_ch <= CH_EIGHT) begin
                        n_file = (file_sum > {1'b0, FILE_MAX}) ? FILE_MAX
                                                               : file_sum[POS_W-1:0];
                    end else begin
                        if (r_file != FILE_MAX) begin
                            n_file = r_file + 4'd1;
                        end
                        o_res.vld    = on_board;
                        o_res.kind   = KIND_SQUARE;
                        o_res.square = {rank_m1[2:0], r_file[2:0]};
                        o_res.piece  = piece_code(i_ch);
                    end
                end
                PH_SIDE: begin
                    n_phase    = PH_SEP;
                    o_res.vld  = 1'b1;
                    o_res.kind = KIND_SIDE;
                    o_res.side = (i_ch != CH_LOW_W);
                end
                PH_SEP: begin
                    n_phase = PH_CASTLE;
                end
                PH_CASTLE: begin
                    priority if (i_ch == CH_SPACE) begin
                        n_phase           = PH_EP;
                        o_res.vld         = 1'b1;
                        o_res.kind        = KIND_CASTLE;
                        o_res.castle_mask = r_castle;
                    end else if (i_ch == CH_UP_K) begin
                        n_castle = r_castle | CASTLE_WK;
                    end else if (i_ch == CH_UP_Q) begin
                        n_castle = r_castle | CASTLE_WQ;
                    end else if (i_ch == CH_LOW_K) begin
                        n_castle = r_castle | CASTLE_BK;
                    end else if (i_ch == CH_LOW_Q) begin
                        n_castle = r_castle | CASTLE_BQ;
                    end else begin
                        n_castle = r_castle;
                    end
                end
                PH_EP: begin
                    if (i_ch == CH_SPACE) begin
                        n_phase = PH_HALF;
                    end
                end
                PH_HALF: begin
                    if (i_ch == CH_SPACE) begin
                        n_phase = PH_FULL;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (!i_step) begin
            o_res.vld = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== src/fbsp_out_reg.sv =====
// Output register for result words with stream handshake and payload packing.
// Depends on fbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbsp_out_reg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fbsp_pkg::t_result            i_res,
    output logic                         o_free,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [fbsp_pkg::OUT_W-1:0]   o_m_tdata,
    output logic [1:0]                   o_m_tuser
);
    import fbsp_pkg::*;

    logic             r_vld;
    logic [OUT_W-1:0] r_data;
    logic [1:0]       r_user;

    assign o_free = !r_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.vld) begin
            r_data <= {1'b0, i_res.castle_mask, i_res.side, i_res.piece, i_res.square};
            r_user <= i_res.kind;
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

endmodule

`default_nettype wire

// ===== src/fen_board_setup_parser.sv =====
// Top level of the position string parser: input word register, parser core
// and output register. Depends on fbsp_pkg, fbsp_parse and fbsp_out_reg.
//
// Usage: characters of a position string enter on the slave stream, one per
// word in s_tdata[7:0]. Each character gives zero or one result word on the
// master stream. Result kind is in m_tuser; m_tdata carries square, piece,
// side and castling mask. A NUL character ends the record with a done word
// and rearms the parser for the next string.
// A result word is valid once the output register holds it: the character is
// registered at the accepting edge, and the parser logic then loads the output
// register when it is free. Throughput is one character per cycle
// while the receiver takes results; each stage is a single register.
// Reset clears the parser to the start of the placement field, rank 8, file
// 0, with no castling bits, and empties both registers.
// When the receiver stalls, the output register holds its word, the input
// register takes one more character, and the slave tready then drops until
// the output register is taken.
`timescale 1ns / 1ps
`default_nettype none

module fen_board_setup_parser (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    input  wire  [fbsp_pkg::CH_W-1:0]   i_s_tdata,   // [7:0] ch
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output logic [fbsp_pkg::OUT_W-1:0]  o_m_tdata,   // [5:0] square, [9:6] piece,
                                                     // [10] side, [14:11] castle_mask
    output logic [1:0]                  o_m_tuser    // [1:0] kind
);
    import fbsp_pkg::*;

    logic            r_in_vld;
    logic [CH_W-1:0] r_in_ch;
    logic            out_free;
    logic            step;
    t_result         res;

    assign step       = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch <= i_s_tdata;
        end
    end

    fbsp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_in_ch),
        .o_res   (res)
    );

    fbsp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== src/fbsp_checker.sv =====
// Port-level checker for the position string parser and its bind statement.
// Depends on fbsp_pkg and the fen_board_setup_parser ports.
`timescale 1ns / 1ps
`default_nettype none

module fbsp_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         o_m_tvalid,
    input  wire                         i_m_tready,
    input  wire  [fbsp_pkg::OUT_W-1:0]  o_m_tdata,
    input  wire  [1:0]                  o_m_tuser
);
    import fbsp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_DONE |-> o_m_tdata == '0)
        else $error("done word carries data");

    a_side_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_SIDE |->
            o_m_tdata[9:0] == '0 && o_m_tdata[15:11] == '0)
        else $error("side word carries other fields");

    a_square_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_SQUARE |->
            o_m_tdata[9:6] <= 4'd12 && o_m_tdata[15:10] == '0)
        else $error("square word malformed");

endmodule

bind fen_board_setup_parser fbsp_checker u_fbsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
